// ----- design/poi_pkg.sv -----
package poi_pkg;

    localparam int FRAC_BITS        = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CNT_W            = 5;
    localparam int CFG_W            = 3;
    localparam int CFG_DATA_W       = 32;
    localparam int TDATA_W          = 256;

    // reciprocal divider / modulo unit
    localparam int DIV_W      = 50;
    localparam int MOD_PRE_SH = 28;
    localparam int REC_SH     = 48;
    localparam int REC_SPLIT  = 24;
    localparam longint NS_PER_S = 1000000000;

    localparam longint unsigned PI_Q60 = 64'h3243F6A8885A308D;
    localparam longint PI_F =
        longint'((PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS));
    localparam longint TWO_PI_F = 2 * PI_F;

    // floor(2^48 / divisor), the estimate is never high and at most one short
    localparam longint TS_RECIP  = (longint'(1) << REC_SH) / NS_PER_S;
    localparam longint MOD_RECIP = (longint'(1) << REC_SH) / TWO_PI_F;

    localparam logic [31:0] INV_PI_Q32 = 32'h517CC1B7;
    localparam int          GAIN_Q30   = 652032874;
    localparam int          GUARD      = 16;
    localparam int          PRE_SH     = 30 - GUARD;
    localparam int          XY_W       = 52;
    localparam int          Z_W        = 34;

    typedef enum logic [CFG_W-1:0] {
        CFG_MODE,
        CFG_START_X,
        CFG_START_Y,
        CFG_START_HEADING,
        CFG_START_SEC,
        CFG_START_NSEC
    } cfg_idx_t;

    typedef enum logic [3:0] {
        MUL_W_TS,
        MUL_VX_GAIN,
        MUL_VY_GAIN,
        MUL_R_INV,
        MUL_RX_TS,
        MUL_RY_TS,
        MUL_LO_REC,
        MUL_HI_REC,
        MUL_Q_DSR
    } mul_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RST_REPLY,
        ST_TS_LOAD,
        ST_TS_LO,
        ST_TS_HI,
        ST_TS_Q,
        ST_TS_QD,
        ST_TS_FIX,
        ST_TS_FIN,
        ST_MUL_W,
        ST_ANGLE,
        ST_MOD_LO,
        ST_MOD_HI,
        ST_MOD_Q,
        ST_MOD_QD,
        ST_MOD_FIX,
        ST_MUL_VX,
        ST_MUL_VY,
        ST_CAP_VY,
        ST_MUL_BAM,
        ST_FOLD,
        ST_CORDIC,
        ST_MUL_RX,
        ST_MUL_RY,
        ST_CAP_RY,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic             in_load;
        logic             first_load;
        logic             swap_emit;
        logic             ts_div_load;
        logic             div_mod;
        logic             div_acc;
        logic             div_q;
        logic             div_fix;
        logic             ts_cap;
        logic             angle_cap;
        mul_sel_t         mul_sel;
        logic             x_cap;
        logic             y_cap;
        logic             fold_cap;
        logic             cordic_step;
        logic [CNT_W-1:0] step_idx;
        logic             px_cap;
        logic             py_cap;
        logic             upd_emit;
    } cmd_t;

    typedef struct packed {
        logic in_req;
        logic started;
        logic out_free;
    } status_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // arctangent of 2^-i as a binary angle
    function automatic logic [31:0] atan_bam(input logic [CNT_W-1:0] i);
        logic [31:0] a;
        unique case (i)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933406;
            5'd2:  a = 32'd167458907;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667331;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10679838;
            5'd7:  a = 32'd5340245;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            5'd20: a = 32'd652;
            5'd21: a = 32'd326;
            5'd22: a = 32'd163;
            5'd23: a = 32'd81;
            5'd24: a = 32'd41;
            5'd25: a = 32'd20;
            5'd26: a = 32'd10;
            5'd27: a = 32'd5;
            5'd28: a = 32'd3;
            5'd29: a = 32'd1;
            5'd30: a = 32'd1;
            5'd31: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

// ----- design/poi_ctrl.sv -----
module poi_ctrl #(
    parameter int CORDIC_STEPS = poi_pkg::CORDIC_STEPS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  poi_pkg::status_t st,
    output poi_pkg::cmd_t    cmd
);
    import poi_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.mul_sel  = MUL_W_TS;
        cmd.step_idx = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.in_load = 1'b1;
                    if (st.in_req) begin
                        state_next = ST_RST_REPLY;
                    end else if (!st.started) begin
                        cmd.first_load = 1'b1;
                    end else begin
                        state_next = ST_TS_LOAD;
                    end
                end
            end
            ST_RST_REPLY: begin
                if (st.out_free) begin
                    cmd.swap_emit = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_TS_LOAD: begin
                cmd.ts_div_load = 1'b1;
                state_next      = ST_TS_LO;
            end
            ST_TS_LO: begin
                cmd.mul_sel = MUL_LO_REC;
                state_next  = ST_TS_HI;
            end
            ST_TS_HI: begin
                cmd.mul_sel = MUL_HI_REC;
                cmd.div_acc = 1'b1;
                state_next  = ST_TS_Q;
            end
            ST_TS_Q: begin
                cmd.div_q  = 1'b1;
                state_next = ST_TS_QD;
            end
            ST_TS_QD: begin
                cmd.mul_sel = MUL_Q_DSR;
                state_next  = ST_TS_FIX;
            end
            ST_TS_FIX: begin
                cmd.div_fix = 1'b1;
                state_next  = ST_TS_FIN;
            end
            ST_TS_FIN: begin
                cmd.ts_cap = 1'b1;
                state_next = ST_MUL_W;
            end
            ST_MUL_W: begin
                cmd.mul_sel = MUL_W_TS;
                state_next  = ST_ANGLE;
            end
            ST_ANGLE: begin
                cmd.angle_cap = 1'b1;
                state_next    = ST_MOD_LO;
            end
            ST_MOD_LO: begin
                cmd.div_mod = 1'b1;
                cmd.mul_sel = MUL_LO_REC;
                state_next  = ST_MOD_HI;
            end
            ST_MOD_HI: begin
                cmd.div_mod = 1'b1;
                cmd.mul_sel = MUL_HI_REC;
                cmd.div_acc = 1'b1;
                state_next  = ST_MOD_Q;
            end
            ST_MOD_Q: begin
                cmd.div_mod = 1'b1;
                cmd.div_q   = 1'b1;
                state_next  = ST_MOD_QD;
            end
            ST_MOD_QD: begin
                cmd.div_mod = 1'b1;
                cmd.mul_sel = MUL_Q_DSR;
                state_next  = ST_MOD_FIX;
            end
            ST_MOD_FIX: begin
                cmd.div_mod = 1'b1;
                cmd.div_fix = 1'b1;
                state_next  = ST_MUL_VX;
            end
            ST_MUL_VX: begin
                cmd.mul_sel = MUL_VX_GAIN;
                state_next  = ST_MUL_VY;
            end
            ST_MUL_VY: begin
                cmd.mul_sel = MUL_VY_GAIN;
                cmd.x_cap   = 1'b1;
                state_next  = ST_CAP_VY;
            end
            ST_CAP_VY: begin
                cmd.y_cap  = 1'b1;
                state_next = ST_MUL_BAM;
            end
            ST_MUL_BAM: begin
                cmd.mul_sel = MUL_R_INV;
                state_next  = ST_FOLD;
            end
            ST_FOLD: begin
                cmd.fold_cap = 1'b1;
                cnt_next     = '0;
                state_next   = ST_CORDIC;
            end
            ST_CORDIC: begin
                cmd.cordic_step = 1'b1;
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_MUL_RX;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MUL_RX: begin
                cmd.mul_sel = MUL_RX_TS;
                state_next  = ST_MUL_RY;
            end
            ST_MUL_RY: begin
                cmd.mul_sel = MUL_RY_TS;
                cmd.px_cap  = 1'b1;
                state_next  = ST_CAP_RY;
            end
            ST_CAP_RY: begin
                cmd.py_cap = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (st.out_free) begin
                    cmd.upd_emit = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/poi_datapath.sv -----
module poi_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [poi_pkg::CFG_W-1:0]         cfg_addr,
    input  logic [poi_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [poi_pkg::TDATA_W-1:0]       s_tdata,
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [poi_pkg::TDATA_W-1:0]       m_tdata,
    output logic                              m_tuser,
    input  poi_pkg::cmd_t                     cmd,
    output poi_pkg::status_t                  st
);
    import poi_pkg::*;

    // configuration
    logic               mode_reg;
    logic signed [31:0] start_x_reg, start_y_reg, start_h_reg;
    logic [30:0]        start_sec_reg;
    logic [29:0]        start_nsec_reg;

    // pose state
    logic               started_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg, yaw_reg;
    logic signed [31:0] org_x_reg, org_y_reg, org_h_reg;
    logic [30:0]        last_sec_reg;
    logic [29:0]        last_nsec_reg;

    // latched request
    logic signed [31:0] vx_reg, vy_reg, w_reg, nx_reg, ny_reg, nh_reg;
    logic [30:0]        sec_reg;
    logic [29:0]        nsec_reg;

    // work registers
    logic signed [31:0]  ds_reg;
    logic                neg_reg;
    logic [DIV_W-1:0]    rem_reg;
    logic [31:0]         quo_reg, acc_reg;
    logic signed [31:0]  ts_reg, yaw_new_reg, px_reg, py_reg;
    logic signed [65:0]  mul_reg;
    logic signed [XY_W-1:0] x_reg, y_reg;
    logic signed [Z_W-1:0]  z_reg;

    // output register
    logic               out_valid_reg;
    logic               out_kind_reg;
    logic signed [31:0] o_px_reg, o_py_reg, o_h_reg, o_rx_reg, o_ry_reg, o_rh_reg;
    logic [30:0]        o_sec_reg;
    logic [29:0]        o_nsec_reg;

    logic               out_free;
    logic signed [31:0] dn_s_ds;
    logic signed [30:0] dn;
    logic [30:0]        mag;
    logic               ge;
    logic [31:0]        rec, dvs, q_est;
    logic [DIV_W-1:0]   diff;
    logic signed [DIV_W-1:0] ts_wide;
    logic signed [63:0] prod, turn, half, angle;
    logic signed [32:0] mul_a, mul_b;
    logic [31:0]        bam, bam_f;
    logic               flip;
    logic signed [XY_W-1:0] xs, ys;
    logic signed [31:0] rx, ry;

    assign out_free = !out_valid_reg || m_tready;
    assign st.in_req   = s_tuser;
    assign st.started  = started_reg;
    assign st.out_free = out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= 1'b0;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            start_h_reg    <= '0;
            start_sec_reg  <= '0;
            start_nsec_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_MODE:          mode_reg       <= cfg_wdata[0];
                CFG_START_X:       start_x_reg    <= cfg_wdata;
                CFG_START_Y:       start_y_reg    <= cfg_wdata;
                CFG_START_HEADING: start_h_reg    <= cfg_wdata;
                CFG_START_SEC:     start_sec_reg  <= cfg_wdata[30:0];
                CFG_START_NSEC:    start_nsec_reg <= cfg_wdata[29:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            vx_reg   <= s_tdata[31:0];
            vy_reg   <= s_tdata[63:32];
            w_reg    <= s_tdata[95:64];
            sec_reg  <= s_tdata[126:96];
            nsec_reg <= s_tdata[156:127];
            nx_reg   <= s_tdata[188:157];
            ny_reg   <= s_tdata[220:189];
            nh_reg   <= s_tdata[252:221];
        end
    end

    // timestamp difference
    assign dn_s_ds = signed'({1'b0, sec_reg}) - signed'({1'b0, last_sec_reg});
    assign dn      = signed'({1'b0, nsec_reg}) - signed'({1'b0, last_nsec_reg});
    assign mag     = dn[30] ? 31'(-dn) : 31'(dn);
    assign ts_wide = (DIV_W'(ds_reg) <<< FRAC_BITS)
                   + (neg_reg ? -signed'(DIV_W'(quo_reg)) : signed'(DIV_W'(quo_reg)));

    // reciprocal quotient estimate, then one compare and subtract
    assign rec   = cmd.div_mod ? 32'(MOD_RECIP) : 32'(TS_RECIP);
    assign dvs   = cmd.div_mod ? 32'(TWO_PI_F) : 32'(NS_PER_S);
    assign q_est = 32'((mul_reg[63:0] + 64'(acc_reg)) >> REC_SPLIT);
    assign diff  = rem_reg - mul_reg[DIV_W-1:0];
    assign ge    = diff >= DIV_W'(dvs);

    // heading turn and rotation angle
    assign prod  = mul_reg[63:0];
    assign turn  = (prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign half  = (prod + (64'sd1 <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
    assign angle = 64'(yaw_reg) + (mode_reg ? half : 64'sd0);

    always_ff @(posedge aclk) begin
        if (cmd.ts_div_load) begin
            ds_reg  <= dn_s_ds;
            neg_reg <= dn[30];
            rem_reg <= (DIV_W'(mag) << FRAC_BITS) + DIV_W'(NS_PER_S / 2);
        end else if (cmd.angle_cap) begin
            // offset by a whole number of turns so the value is never negative
            rem_reg <= DIV_W'(angle + (64'(TWO_PI_F) <<< MOD_PRE_SH));
        end else if (cmd.div_fix) begin
            rem_reg <= ge ? diff - DIV_W'(dvs) : diff;
        end
        if (cmd.div_acc) begin
            acc_reg <= mul_reg[REC_SPLIT+31:REC_SPLIT];
        end
        if (cmd.div_q) begin
            quo_reg <= q_est;
        end else if (cmd.div_fix) begin
            quo_reg <= quo_reg + 32'(ge);
        end
        if (cmd.ts_cap) begin
            ts_reg <= sat32(64'(ts_wide));
        end
        if (cmd.angle_cap) begin
            yaw_new_reg <= sat32(64'(yaw_reg) + turn);
        end
    end

    // shared multiplier
    assign rx = sat32(64'((x_reg + (XY_W'(1) <<< (GUARD - 1))) >>> GUARD));
    assign ry = sat32(64'((y_reg + (XY_W'(1) <<< (GUARD - 1))) >>> GUARD));

    always_comb begin
        unique case (cmd.mul_sel)
            MUL_W_TS: begin
                mul_a = 33'(w_reg);
                mul_b = 33'(ts_reg);
            end
            MUL_VX_GAIN: begin
                mul_a = 33'(vx_reg);
                mul_b = 33'(GAIN_Q30);
            end
            MUL_VY_GAIN: begin
                mul_a = 33'(vy_reg);
                mul_b = 33'(GAIN_Q30);
            end
            MUL_R_INV: begin
                mul_a = signed'({1'b0, rem_reg[31:0]});
                mul_b = signed'({1'b0, INV_PI_Q32});
            end
            MUL_RX_TS: begin
                mul_a = 33'(rx);
                mul_b = 33'(ts_reg);
            end
            MUL_RY_TS: begin
                mul_a = 33'(ry);
                mul_b = 33'(ts_reg);
            end
            MUL_LO_REC: begin
                mul_a = 33'(rem_reg[REC_SPLIT-1:0]);
                mul_b = signed'({1'b0, rec});
            end
            MUL_HI_REC: begin
                mul_a = 33'(rem_reg[2*REC_SPLIT-1:REC_SPLIT]);
                mul_b = signed'({1'b0, rec});
            end
            MUL_Q_DSR: begin
                mul_a = signed'({1'b0, quo_reg});
                mul_b = signed'({1'b0, dvs});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        mul_reg <= mul_a * mul_b;
    end

    // quadrant fold and cordic
    assign bam   = mul_reg[FRAC_BITS+32:FRAC_BITS+1];
    assign flip  = (bam[31:30] == 2'b01) || (bam[31:30] == 2'b10);
    assign bam_f = flip ? bam + 32'h80000000 : bam;
    assign xs    = x_reg >>> cmd.step_idx;
    assign ys    = y_reg >>> cmd.step_idx;

    always_ff @(posedge aclk) begin
        if (cmd.x_cap) begin
            x_reg <= XY_W'((mul_reg + (66'sd1 <<< (PRE_SH - 1))) >>> PRE_SH);
        end else if (cmd.fold_cap) begin
            x_reg <= flip ? -x_reg : x_reg;
        end else if (cmd.cordic_step) begin
            x_reg <= z_reg[Z_W-1] ? x_reg + ys : x_reg - ys;
        end
        if (cmd.y_cap) begin
            y_reg <= XY_W'((mul_reg + (66'sd1 <<< (PRE_SH - 1))) >>> PRE_SH);
        end else if (cmd.fold_cap) begin
            y_reg <= flip ? -y_reg : y_reg;
        end else if (cmd.cordic_step) begin
            y_reg <= z_reg[Z_W-1] ? y_reg - xs : y_reg + xs;
        end
        if (cmd.fold_cap) begin
            z_reg <= Z_W'(signed'(bam_f));
        end else if (cmd.cordic_step) begin
            z_reg <= z_reg[Z_W-1] ? z_reg + signed'(Z_W'(atan_bam(cmd.step_idx)))
                                  : z_reg - signed'(Z_W'(atan_bam(cmd.step_idx)));
        end
        if (cmd.px_cap) begin
            px_reg <= sat32(64'(pos_x_reg)
                + ((64'(mul_reg) + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS));
        end
        if (cmd.py_cap) begin
            py_reg <= sat32(64'(pos_y_reg)
                + ((64'(mul_reg) + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS));
        end
    end

    // pose state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg   <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            yaw_reg       <= '0;
            org_x_reg     <= '0;
            org_y_reg     <= '0;
            org_h_reg     <= '0;
            last_sec_reg  <= '0;
            last_nsec_reg <= '0;
        end else if (cmd.first_load) begin
            started_reg   <= 1'b1;
            pos_x_reg     <= start_x_reg;
            pos_y_reg     <= start_y_reg;
            yaw_reg       <= start_h_reg;
            org_x_reg     <= start_x_reg;
            org_y_reg     <= start_y_reg;
            org_h_reg     <= start_h_reg;
            last_sec_reg  <= start_sec_reg;
            last_nsec_reg <= start_nsec_reg;
        end else if (cmd.swap_emit) begin
            pos_x_reg <= nx_reg;
            pos_y_reg <= ny_reg;
            yaw_reg   <= nh_reg;
        end else if (cmd.upd_emit) begin
            pos_x_reg     <= px_reg;
            pos_y_reg     <= py_reg;
            yaw_reg       <= yaw_new_reg;
            last_sec_reg  <= sec_reg;
            last_nsec_reg <= nsec_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.swap_emit || cmd.upd_emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.swap_emit) begin
            out_kind_reg <= 1'b1;
            o_px_reg     <= pos_x_reg;
            o_py_reg     <= pos_y_reg;
            o_h_reg      <= yaw_reg;
            o_rx_reg     <= sat32(64'(pos_x_reg) - 64'(org_x_reg));
            o_ry_reg     <= sat32(64'(pos_y_reg) - 64'(org_y_reg));
            o_rh_reg     <= sat32(64'(yaw_reg) - 64'(org_h_reg));
            o_sec_reg    <= last_sec_reg;
            o_nsec_reg   <= last_nsec_reg;
        end else if (cmd.upd_emit) begin
            out_kind_reg <= 1'b0;
            o_px_reg     <= px_reg;
            o_py_reg     <= py_reg;
            o_h_reg      <= yaw_new_reg;
            o_rx_reg     <= sat32(64'(px_reg) - 64'(org_x_reg));
            o_ry_reg     <= sat32(64'(py_reg) - 64'(org_y_reg));
            o_rh_reg     <= sat32(64'(yaw_new_reg) - 64'(org_h_reg));
            o_sec_reg    <= sec_reg;
            o_nsec_reg   <= nsec_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {3'b000, o_nsec_reg, o_sec_reg, o_rh_reg, o_ry_reg, o_rx_reg,
                       o_h_reg, o_py_reg, o_px_reg};

endmodule

// ----- design/planar_odometry_integrator.sv -----
// channel  | dir | tdata (lsb up)                                           | tuser
// s_       | in  | vel_x vel_y turn_rate stamp_sec stamp_nsec new_x new_y   | req_type
//          |     | new_heading, zero padded to 256                          |
// m_       | out | pose_x pose_y heading rel_x rel_y rel_heading out_sec    | result_kind
//          |     | out_nsec, zero padded to 256                             |
// cfg      | in  | write enable, index 0..5, 32-bit data                    | -
//
// a velocity sample: a reciprocal multiply and one correction give the time step and the angle
// modulo in turn, then one cordic step a cycle
// a pose reset request passes through the reply state; the first sample is taken in the idle state
// one request is in flight at a time; s_tready is high only when the engine is idle
// a full result register stalls the engine just before it writes the next result
// reset is synchronous; pose, origin, time and configuration clear to zero
module planar_odometry_integrator #(
    parameter int CORDIC_STEPS = poi_pkg::CORDIC_STEPS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [poi_pkg::CFG_W-1:0]      cfg_addr,
    input  logic [poi_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // vel_x, vel_y, turn_rate, stamp_sec, stamp_nsec, new_x, new_y, new_heading
    input  logic [poi_pkg::TDATA_W-1:0]    s_tdata,
    // req_type
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // pose_x, pose_y, heading, rel_x, rel_y, rel_heading, out_sec, out_nsec
    output logic [poi_pkg::TDATA_W-1:0]    m_tdata,
    // result_kind
    output logic                           m_tuser
);
    import poi_pkg::*;

    cmd_t    cmd;
    status_t st;

    poi_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    poi_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

// ----- design/poi_checker.sv -----
module poi_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        s_tuser,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic                        m_tuser
);

    // a stalled result stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // no result straight out of reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a pose reset request occupies the engine
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("request taken during pose reset");

    // a pose reset request into an empty output is answered through the reply state, with no stall
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser && !m_tvalid |-> ##2 (m_tvalid && m_tuser))
        else $error("missing reset reply");

endmodule

bind planar_odometry_integrator poi_checker u_poi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser)
);
